// File: hdl/mptt_pkg.sv
`default_nettype none

package mptt_pkg;

    localparam int COORD_W  = 32;
    localparam int STEP_W   = COORD_W - 1;
    localparam int DELTA_W  = COORD_W + 1;
    localparam int SQ_W     = 2 * COORD_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int RAD_W    = SUM_W + (SUM_W % 2);
    localparam int ROOT_W   = RAD_W / 2;
    localparam int QUO_W    = COORD_W;
    localparam int NUM_W    = 2 * QUO_W;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_MOVED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic               neg_x;
        logic               neg_y;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [STEP_W-1:0]  step;
        logic               clamp;
        logic               err;
    } t_sqrt_side;

    typedef struct packed {
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
        logic               neg_x;
        logic               neg_y;
        logic               clamp;
        logic               err;
    } t_div_side;

    localparam int SQRT_SIDE_W = $bits(t_sqrt_side);
    localparam int DIV_SIDE_W  = $bits(t_div_side);

endpackage

`default_nettype wire

// File: hdl/mptt_sqrt.sv
`default_nettype none

module mptt_sqrt #(
    parameter int RAD_W  = mptt_pkg::RAD_W,
    parameter int SIDE_W = mptt_pkg::SQRT_SIDE_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire logic [RAD_W-1:0]  i_rad,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_vld,
    output logic [RAD_W/2-1:0]     o_root,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic              r_vld  [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic              p_vld;
        logic [RAD_W-1:0]  p_rad;
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SIDE_W-1:0] p_side;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_side = r_side[k-1];
        end

        always_comb begin
            rem_sh = {p_rem[REM_W-3:0], p_rad[RAD_W-1:RAD_W-2]};
            trial  = {1'b0, p_root, 2'b01};
            ge     = (rem_sh >= trial);
            n_rem  = ge ? (rem_sh - trial) : rem_sh;
            n_root = {p_root[ROOT_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
            r_rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
            r_rem[k]  <= n_rem;
            r_root[k] <= n_root;
            r_side[k] <= p_side;
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

`default_nettype wire

// File: hdl/mptt_div.sv
`default_nettype none

module mptt_div #(
    parameter int QUO_W  = mptt_pkg::QUO_W,
    parameter int DEN_W  = mptt_pkg::ROOT_W,
    parameter int SIDE_W = mptt_pkg::DIV_SIDE_W
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [2*QUO_W-1:0] i_num_x,
    input  wire logic [2*QUO_W-1:0] i_num_y,
    input  wire logic [DEN_W-1:0]   i_den,
    input  wire logic [SIDE_W-1:0]  i_side,
    output logic                    o_vld,
    output logic [QUO_W-1:0]        o_q_x,
    output logic [QUO_W-1:0]        o_q_y,
    output logic [SIDE_W-1:0]       o_side
);

    localparam int NUM_W = 2 * QUO_W;

    logic              r_vld   [QUO_W];
    logic [DEN_W-1:0]  r_den   [QUO_W];
    logic [QUO_W-1:0]  r_low_x [QUO_W];
    logic [QUO_W-1:0]  r_low_y [QUO_W];
    logic [DEN_W-1:0]  r_rem_x [QUO_W];
    logic [DEN_W-1:0]  r_rem_y [QUO_W];
    logic [QUO_W-1:0]  r_q_x   [QUO_W];
    logic [QUO_W-1:0]  r_q_y   [QUO_W];
    logic [SIDE_W-1:0] r_side  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              p_vld;
        logic [DEN_W-1:0]  p_den;
        logic [QUO_W-1:0]  p_low_x;
        logic [QUO_W-1:0]  p_low_y;
        logic [DEN_W-1:0]  p_rem_x;
        logic [DEN_W-1:0]  p_rem_y;
        logic [QUO_W-1:0]  p_q_x;
        logic [QUO_W-1:0]  p_q_y;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    sh_x;
        logic [DEN_W:0]    sh_y;
        logic [DEN_W:0]    den_ext;
        logic              ge_x;
        logic              ge_y;
        logic [DEN_W:0]    dif_x;
        logic [DEN_W:0]    dif_y;

        if (k == 0) begin : g_first
            assign p_vld   = i_vld;
            assign p_den   = i_den;
            assign p_low_x = i_num_x[QUO_W-1:0];
            assign p_low_y = i_num_y[QUO_W-1:0];
            assign p_rem_x = DEN_W'(i_num_x[NUM_W-1:QUO_W]);
            assign p_rem_y = DEN_W'(i_num_y[NUM_W-1:QUO_W]);
            assign p_q_x   = '0;
            assign p_q_y   = '0;
            assign p_side  = i_side;
        end else begin : g_next
            assign p_vld   = r_vld[k-1];
            assign p_den   = r_den[k-1];
            assign p_low_x = r_low_x[k-1];
            assign p_low_y = r_low_y[k-1];
            assign p_rem_x = r_rem_x[k-1];
            assign p_rem_y = r_rem_y[k-1];
            assign p_q_x   = r_q_x[k-1];
            assign p_q_y   = r_q_y[k-1];
            assign p_side  = r_side[k-1];
        end

        always_comb begin
            den_ext = {1'b0, p_den};
            sh_x    = {p_rem_x, p_low_x[QUO_W-1]};
            sh_y    = {p_rem_y, p_low_y[QUO_W-1]};
            ge_x    = (sh_x >= den_ext);
            ge_y    = (sh_y >= den_ext);
            dif_x   = ge_x ? (sh_x - den_ext) : sh_x;
            dif_y   = ge_y ? (sh_y - den_ext) : sh_y;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= p_vld;
            end
            r_den[k]   <= p_den;
            r_low_x[k] <= {p_low_x[QUO_W-2:0], 1'b0};
            r_low_y[k] <= {p_low_y[QUO_W-2:0], 1'b0};
            r_rem_x[k] <= dif_x[DEN_W-1:0];
            r_rem_y[k] <= dif_y[DEN_W-1:0];
            r_q_x[k]   <= {p_q_x[QUO_W-2:0], ge_x};
            r_q_y[k]   <= {p_q_y[QUO_W-2:0], ge_y};
            r_side[k]  <= p_side;
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_q_x  = r_q_x[QUO_W-1];
    assign o_q_y  = r_q_y[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

`default_nettype wire

// File: hdl/move_point_towards_target_core.sv
// Pipeline: an accepted item reaches the result strobe through the stage registers
// (5 front stages, the first loading at the edge that accepts the item, 33 square-root stages,
// 2 scaling stages, 32 divider stages, output).
// Throughput: one item per cycle; busy is always low since the pipeline never stalls.
// Reset (synchronous, active low) clears only the stage valid bits; items in flight drop.
`default_nettype none

module move_point_towards_target_core #(
    parameter int SQRT_SIDE_W = mptt_pkg::SQRT_SIDE_W,
    parameter int DIV_SIDE_W  = mptt_pkg::DIV_SIDE_W
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic signed [31:0]          i_origin_x,
    input  wire logic signed [31:0]          i_origin_y,
    input  wire logic signed [31:0]          i_target_x,
    input  wire logic signed [31:0]          i_target_y,
    input  wire logic signed [31:0]          i_step_length,
    output logic                             o_strobe,
    output logic signed [31:0]               o_new_x,
    output logic signed [31:0]               o_new_y,
    output logic [mptt_pkg::STATUS_W-1:0]    o_status
);

    localparam int CW  = mptt_pkg::COORD_W;
    localparam int SW  = mptt_pkg::STEP_W;
    localparam int DW  = mptt_pkg::DELTA_W;
    localparam int QW  = mptt_pkg::SQ_W;
    localparam int UW  = mptt_pkg::SUM_W;
    localparam int RW  = mptt_pkg::RAD_W;
    localparam int TW  = mptt_pkg::ROOT_W;
    localparam int NW  = mptt_pkg::NUM_W;

    assign busy = 1'b0;

    logic             r_a_vld;
    logic [CW-1:0]    r_a_ox, r_a_oy, r_a_tx, r_a_ty;
    logic [DW-1:0]    r_a_dx, r_a_dy;
    logic [SW-1:0]    r_a_step;
    logic             r_a_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start;
        end
        r_a_ox   <= i_origin_x;
        r_a_oy   <= i_origin_y;
        r_a_tx   <= i_target_x;
        r_a_ty   <= i_target_y;
        r_a_dx   <= {i_target_x[CW-1], i_target_x} - {i_origin_x[CW-1], i_origin_x};
        r_a_dy   <= {i_target_y[CW-1], i_target_y} - {i_origin_y[CW-1], i_origin_y};
        r_a_step <= i_step_length[SW-1:0];
        r_a_err  <= i_step_length[CW-1];
    end

    logic                  r_b_vld;
    mptt_pkg::t_sqrt_side  r_b_side;
    mptt_pkg::t_sqrt_side  n_b_side;
    logic [DW-1:0]         b_nx, b_ny;

    always_comb begin
        b_nx           = -r_a_dx;
        b_ny           = -r_a_dy;
        n_b_side.ox    = r_a_ox;
        n_b_side.oy    = r_a_oy;
        n_b_side.tx    = r_a_tx;
        n_b_side.ty    = r_a_ty;
        n_b_side.neg_x = r_a_dx[DW-1];
        n_b_side.neg_y = r_a_dy[DW-1];
        n_b_side.ax    = r_a_dx[DW-1] ? b_nx[CW-1:0] : r_a_dx[CW-1:0];
        n_b_side.ay    = r_a_dy[DW-1] ? b_ny[CW-1:0] : r_a_dy[CW-1:0];
        n_b_side.step  = r_a_step;
        n_b_side.clamp = 1'b0;
        n_b_side.err   = r_a_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_side <= n_b_side;
    end

    logic                  r_c_vld;
    mptt_pkg::t_sqrt_side  r_c_side;
    logic [QW-1:0]         r_c_sx, r_c_sy;
    logic [2*SW-1:0]       r_c_stsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_side <= r_b_side;
        r_c_sx   <= r_b_side.ax * r_b_side.ax;
        r_c_sy   <= r_b_side.ay * r_b_side.ay;
        r_c_stsq <= r_b_side.step * r_b_side.step;
    end

    logic                  r_d_vld;
    mptt_pkg::t_sqrt_side  r_d_side;
    logic [UW-1:0]         r_d_s;
    logic [2*SW-1:0]       r_d_stsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_side <= r_c_side;
        r_d_s    <= {1'b0, r_c_sx} + {1'b0, r_c_sy};
        r_d_stsq <= r_c_stsq;
    end

    logic                  r_e_vld;
    mptt_pkg::t_sqrt_side  r_e_side;
    mptt_pkg::t_sqrt_side  n_e_side;
    logic [RW-1:0]         r_e_rad;

    always_comb begin
        n_e_side       = r_d_side;
        n_e_side.clamp = (r_d_s == '0) || (UW'(r_d_stsq) > r_d_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= r_d_vld;
        end
        r_e_side <= n_e_side;
        r_e_rad  <= RW'(r_d_s);
    end

    logic                  sq_vld;
    logic [TW-1:0]         sq_root;
    logic [SQRT_SIDE_W-1:0] sq_side_bits;
    mptt_pkg::t_sqrt_side  sq_side;

    mptt_sqrt #(
        .RAD_W  (RW),
        .SIDE_W (SQRT_SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_e_vld),
        .i_rad   (r_e_rad),
        .i_side  (SQRT_SIDE_W'(r_e_side)),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side_bits)
    );

    assign sq_side = mptt_pkg::t_sqrt_side'(sq_side_bits);

    logic                  r_f_vld;
    logic [CW+SW-1:0]      r_f_px, r_f_py;
    logic [TW-1:0]         r_f_d;
    mptt_pkg::t_div_side   r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= sq_vld;
        end
        r_f_px         <= sq_side.ax * sq_side.step;
        r_f_py         <= sq_side.ay * sq_side.step;
        r_f_d          <= sq_root;
        r_f_side.ox    <= sq_side.ox;
        r_f_side.oy    <= sq_side.oy;
        r_f_side.tx    <= sq_side.tx;
        r_f_side.ty    <= sq_side.ty;
        r_f_side.neg_x <= sq_side.neg_x;
        r_f_side.neg_y <= sq_side.neg_y;
        r_f_side.clamp <= sq_side.clamp;
        r_f_side.err   <= sq_side.err;
    end

    logic                  r_g_vld;
    logic [NW-1:0]         r_g_nx, r_g_ny;
    logic [TW-1:0]         r_g_d;
    mptt_pkg::t_div_side   r_g_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else begin
            r_g_vld <= r_f_vld;
        end
        r_g_nx   <= NW'(r_f_px) + NW'(r_f_d[TW-1:1]);
        r_g_ny   <= NW'(r_f_py) + NW'(r_f_d[TW-1:1]);
        r_g_d    <= r_f_d;
        r_g_side <= r_f_side;
    end

    logic                  dv_vld;
    logic [CW-1:0]         dv_qx, dv_qy;
    logic [DIV_SIDE_W-1:0] dv_side_bits;
    mptt_pkg::t_div_side   dv_side;

    mptt_div #(
        .QUO_W  (mptt_pkg::QUO_W),
        .DEN_W  (TW),
        .SIDE_W (DIV_SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_g_vld),
        .i_num_x (r_g_nx),
        .i_num_y (r_g_ny),
        .i_den   (r_g_d),
        .i_side  (DIV_SIDE_W'(r_g_side)),
        .o_vld   (dv_vld),
        .o_q_x   (dv_qx),
        .o_q_y   (dv_qy),
        .o_side  (dv_side_bits)
    );

    assign dv_side = mptt_pkg::t_div_side'(dv_side_bits);

    logic                         r_o_vld;
    logic [CW-1:0]                r_o_x, r_o_y;
    logic [mptt_pkg::STATUS_W-1:0] r_o_st;
    logic [CW-1:0]                n_o_x, n_o_y;
    logic [mptt_pkg::STATUS_W-1:0] n_o_st;

    always_comb begin
        priority if (dv_side.err) begin
            n_o_x  = '0;
            n_o_y  = '0;
            n_o_st = mptt_pkg::ST_ERROR;
        end else if (dv_side.clamp) begin
            n_o_x  = dv_side.tx;
            n_o_y  = dv_side.ty;
            n_o_st = mptt_pkg::ST_CLAMP;
        end else begin
            n_o_x  = dv_side.neg_x ? (dv_side.ox - dv_qx) : (dv_side.ox + dv_qx);
            n_o_y  = dv_side.neg_y ? (dv_side.oy - dv_qy) : (dv_side.oy + dv_qy);
            n_o_st = mptt_pkg::ST_MOVED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= dv_vld;
        end
        r_o_x  <= n_o_x;
        r_o_y  <= n_o_y;
        r_o_st <= n_o_st;
    end

    assign o_strobe = r_o_vld;
    assign o_new_x  = r_o_x;
    assign o_new_y  = r_o_y;
    assign o_status = r_o_st;

endmodule

`default_nettype wire
